### sv/lphi_pkg.sv
// Package for the linear-probe hash index: word types, slot row layout,
// command/status codes and the FNV-1a step. No dependencies.
`timescale 1ns / 1ps
package lphi_pkg;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MISS      = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_EMPTY_KEY = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [47:0] payload_offset;
    logic [31:0] payload_length;
    logic [7:0]  record_kind;
    logic [63:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] found_offset;
    logic [31:0] found_length;
    logic [7:0]  found_kind;
    logic [63:0] found_timestamp;
    logic [6:0]  live_keys;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [47:0] offset;
    logic [31:0] length;
    logic [7:0]  kind;
    logic [63:0] timestamp;
  } slot_row_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic probe_start;
    logic rd;
    logic eval;
    logic finish;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic hash_done;
    logic probe_stop;
    logic clear_last;
  } dp_stat_t;

  // One FNV-1a byte step; the prime is 2^40 + 0x1B3, so the product is shift-add.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    begin
      x = h ^ {56'd0, b};
      fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    end
  endfunction

endpackage

### sv/lphi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sv/lphi_dpath.sv
// Datapath: word capture, FNV-1a hash (non-standard offset basis), probe
// walk over the slot RAM, counters and result word. Uses lphi_pkg, lphi_ram.
`timescale 1ns / 1ps
module lphi_dpath #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BYTES   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lphi_pkg::in_word_t  in_word,
  input  lphi_pkg::dp_cmd_t   cmd,
  output lphi_pkg::dp_stat_t  stat,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_data,
  output lphi_pkg::out_word_t out_word
);
  import lphi_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [3:0] KB = 4'(KEY_BYTES);

  logic [1:0]       cmd_r;
  logic [63:0]      key_r;
  logic [3:0]       len_r;
  logic [47:0]      off_r;
  logic [31:0]      plen_r;
  logic [7:0]       kind_r;
  logic [63:0]      ts_r;
  logic [63:0]      hash_r;
  logic [3:0]       byte_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] step_r;
  logic             tomb_v_r;
  logic [IDX_W-1:0] tomb_idx_r;
  logic             hit_r;
  logic             empty_stop_r;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [5:0]       max_fill_r;
  out_word_t        out_r, out_nxt;

  logic [3:0]       len_c;
  logic [63:0]      key_c;
  slot_row_t        rdata, wr_row, new_row;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             is_match, is_empty, is_tomb, at_last;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W:0]   fill_plus;
  logic [CNT_W+6:0] live_ext;

  // clamp length, drop key bytes past it
  always_comb begin
    len_c = (in_word.key_len > KB) ? KB : in_word.key_len;
    for (int b = 0; b < 8; b++) begin
      key_c[8*b +: 8] = (4'(b) < len_c) ? in_word.key_bytes[8*b +: 8] : 8'd0;
    end
  end

  assign is_empty = (rdata.state == SLOT_EMPTY);
  assign is_tomb  = (rdata.state == SLOT_TOMB);
  assign is_match = (rdata.state == SLOT_USED) && (rdata.key_len == len_r) &&
                    (rdata.key == key_r);
  assign at_last  = (step_r == CNT_LAST);

  assign stat.skip       = (len_c == 4'd0) || (in_word.command != CMD_PUT &&
                           in_word.command != CMD_DELETE && in_word.command != CMD_LOOKUP);
  assign stat.hash_done  = (byte_r == len_r);
  assign stat.probe_stop = is_empty || is_match || at_last;
  assign stat.clear_last = (idx_r == IDX_LAST);

  assign free_ok   = tomb_v_r || empty_stop_r;
  assign free_idx  = tomb_v_r ? tomb_idx_r : idx_r;
  assign fill_plus = {1'b0, fill_r} + (CNT_W+1)'(1);

  always_comb begin
    new_row.state     = SLOT_USED;
    new_row.key       = key_r;
    new_row.key_len   = len_r;
    new_row.offset    = off_r;
    new_row.length    = plen_r;
    new_row.kind      = kind_r;
    new_row.timestamp = ts_r;

    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_row   = new_row;
    live_nxt = live_r;
    fill_nxt = fill_r;
    out_nxt  = '0;
    out_nxt.status = STAT_MISS;

    if (cmd.clear_step) begin
      wr_en = 1'b1;
      wr_row.state = SLOT_EMPTY;
    end else if (cmd.finish) begin
      if (len_r == 4'd0) begin
        out_nxt.status = (cmd_r == CMD_PUT) ? STAT_EMPTY_KEY : STAT_MISS;
      end else begin
        case (cmd_r)
          CMD_PUT: begin
            if (hit_r) begin
              wr_en = 1'b1;
              out_nxt.status = STAT_OK;
            end else if (!free_ok) begin
              out_nxt.status = STAT_FULL;
            end else if (!tomb_v_r && fill_plus > (CNT_W+1)'(max_fill_r)) begin
              out_nxt.status = STAT_FULL;
            end else begin
              wr_en = 1'b1;
              wr_addr = free_idx;
              live_nxt = live_r + CNT_W'(1);
              if (!tomb_v_r) begin
                fill_nxt = fill_r + CNT_W'(1);
              end
              out_nxt.status = STAT_OK;
            end
          end
          CMD_DELETE: begin
            if (hit_r) begin
              wr_en = 1'b1;
              wr_row.state = SLOT_TOMB;
              if (live_r != '0) begin
                live_nxt = live_r - CNT_W'(1);
              end
              out_nxt.status = STAT_OK;
            end
          end
          CMD_LOOKUP: begin
            if (hit_r) begin
              out_nxt.status          = STAT_OK;
              out_nxt.found_offset    = rdata.offset;
              out_nxt.found_length    = rdata.length;
              out_nxt.found_kind      = rdata.kind;
              out_nxt.found_timestamp = rdata.timestamp;
            end
          end
          default: begin
            out_nxt.status = STAT_MISS;
          end
        endcase
      end
    end
    live_ext = {7'd0, live_nxt};
    out_nxt.live_keys = live_ext[6:0];
  end

  lphi_ram #(
    .WIDTH($bits(slot_row_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_row),
    .re   (cmd.rd),
    .raddr(idx_r),
    .rdata(rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      live_r     <= '0;
      fill_r     <= '0;
      max_fill_r <= 6'd44;
      tomb_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_fill_r <= cfg_data;
      end
      if (cmd.clear_step) begin
        idx_r <= stat.clear_last ? '0 : idx_r + IDX_W'(1);
      end
      if (cmd.probe_start) begin
        idx_r    <= hash_r[IDX_W-1:0] & IDX_LAST;
        tomb_v_r <= 1'b0;
      end
      if (cmd.eval) begin
        if (is_tomb && !tomb_v_r) begin
          tomb_v_r <= 1'b1;
        end
        if (!stat.probe_stop) begin
          idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
        end
      end
      if (cmd.finish) begin
        live_r <= live_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_word.command;
      key_r  <= key_c;
      len_r  <= len_c;
      off_r  <= in_word.payload_offset;
      plen_r <= in_word.payload_length;
      kind_r <= in_word.record_kind;
      ts_r   <= in_word.timestamp;
      hash_r <= FNV_BASIS;
      byte_r <= 4'd0;
    end
    if (cmd.hash_step) begin
      hash_r <= fnv_step(hash_r, key_r[{byte_r[2:0], 3'b000} +: 8]);
      byte_r <= byte_r + 4'd1;
    end
    if (cmd.probe_start) begin
      step_r <= '0;
    end
    if (cmd.eval) begin
      hit_r        <= is_match;
      empty_stop_r <= is_empty;
      if (is_tomb && !tomb_v_r) begin
        tomb_idx_r <= idx_r;
      end
      if (!stat.probe_stop) begin
        step_r <= step_r + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;
endmodule

### sv/lphi_ctrl.sv
// Controller of the hash index: clearing pass, hash, probe and finish
// sequencing plus both handshakes. Uses lphi_pkg.
`timescale 1ns / 1ps
module lphi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lphi_pkg::dp_cmd_t cmd,
  input  lphi_pkg::dp_stat_t stat
);
  import lphi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.skip ? S_FIN : S_HASH;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.probe_start = 1'b1;
          state_nxt       = S_READ;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.probe_stop ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
endmodule

### sv/linear_probe_hash_index_core.sv
// Linear-probe hash index: FNV-1a steps (non-standard basis), tombstone deletes.
// Keys hash one byte per cycle; each probed slot then gets a registered slot
// RAM read and a compare; an empty key or unused command skips both. The
// result is registered once the output is free. One word in flight; the
// result register frees the input. Reset: sync, active low; then a clearing
// pass over all TABLE_SLOTS slots, in_stall high. Uses lphi_pkg, lphi_ctrl, lphi_dpath.
`timescale 1ns / 1ps
module linear_probe_hash_index_core #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BYTES   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lphi_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lphi_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_data
);
  import lphi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lphi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  lphi_dpath #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BYTES  (KEY_BYTES)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .cmd     (cmd),
    .stat    (stat),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .out_word(out_word)
  );
endmodule

### sv/lphi_checker.sv
// Port-level checks for linear_probe_hash_index_core, bound to the top.
// Uses lphi_pkg.
`timescale 1ns / 1ps
module lphi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input lphi_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input lphi_pkg::out_word_t out_word,
  input logic                cfg_we,
  input logic [5:0]          cfg_data
);
  import lphi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != STAT_OK |->
      out_word.found_offset == '0 && out_word.found_length == '0 &&
      out_word.found_kind == '0 && out_word.found_timestamp == '0)
    else $error("record fields set on a failed command");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken before first finished");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind linear_probe_hash_index_core lphi_checker u_lphi_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word),
  .cfg_we   (cfg_we),
  .cfg_data (cfg_data)
);
